### rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned MaxOrder = 10;
  localparam int unsigned NumPages = 4096;
  localparam int unsigned PageW    = 12;
  localparam int unsigned LinkW    = PageW + 1;
  localparam int unsigned OrdW     = 4;
  localparam int unsigned CntW     = 11;
  localparam int unsigned SumW     = 17;

  // A link with the top bit set points nowhere.
  localparam logic [LinkW-1:0] LinkNil = {1'b1, {PageW{1'b0}}};

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoBlock = 2'd1;
  localparam logic [1:0] StatusTooBig  = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CntW-1:0]  page_count;
    logic [PageW-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] block_start;
  } out_item_t;

  typedef struct packed {
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
    logic             free;
    logic [OrdW-1:0]  order;
  } page_rec_t;

  typedef struct packed {
    logic             en_next;
    logic             en_prev;
    logic             en_free;
    logic             en_order;
    logic [PageW-1:0] addr;
    page_rec_t        data;
  } page_wr_t;

endpackage

### rtl/core/buddy_page_allocator.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | in_item_i  (op, page_count, page_index)
// out     | output    | out_valid_o/out_ready_i| out_item_o (status, block_start)
//
// After reset a clearing pass writes the initial pool into the page memories; no item is
// taken during it.
// A page record read passes a wait state on the single read port. An allocate is accepted,
// then searches the orders, splits, pops the block and hands over the result; an
// oversized request goes straight to the hand-over. A free reads the page and, if it is
// not free, pushes it and tries a merge at each order in turn, then hands over.
// The result sits in an output register, so a new item is taken while it waits; the
// next result stalls in the done state until that register empties.
module buddy_page_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpa_pkg::out_item_t  out_item_o
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RDW, S_SRCH, S_SPL, S_POP1,
    S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
    S_SP2, S_SP3, S_SP4, S_SP5, S_SP6, S_SP7,
    S_FIN1, S_FIN2, S_FCHK, S_PS0, S_PS1,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_DONE
  } state_e;

  localparam logic [bpa_pkg::OrdW-1:0]  MaxOrd = bpa_pkg::OrdW'(bpa_pkg::MaxOrder);
  localparam logic [bpa_pkg::LinkW-1:0] BlkSz  = bpa_pkg::LinkW'(1) << bpa_pkg::MaxOrder;
  localparam logic [bpa_pkg::LinkW-1:0] PoolSz = bpa_pkg::LinkW'(bpa_pkg::NumPages);

  state_e                    state_q, rd_ret_q, sub_ret_q;
  logic [bpa_pkg::LinkW-1:0] head_q [bpa_pkg::MaxOrder+1];
  logic [bpa_pkg::PageW-1:0] init_q, addr_q, p_q, u_q, hi_q, lo_q, idx_q;
  logic [bpa_pkg::LinkW-1:0] nx_q, lf_q, rt_q;
  logic [bpa_pkg::OrdW-1:0]  ord_q, av_q, o_q, k_q, uord_q, pord_q;
  logic                      out_valid_q;
  bpa_pkg::out_item_t        out_q, res_q;

  bpa_pkg::page_rec_t        rec;
  bpa_pkg::page_wr_t         wr;
  logic [bpa_pkg::OrdW-1:0]  unit_ord;
  logic [bpa_pkg::SumW-1:0]  unit_upper;
  logic [bpa_pkg::LinkW-1:0] unit_buddy;
  logic [bpa_pkg::OrdW-1:0]  req_ord;
  logic [bpa_pkg::LinkW-1:0] init_link;

  bpa_page_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (addr_q),
    .rd_data_o (rec),
    .wr_i      (wr)
  );

  assign unit_ord = (state_q == S_MG1) ? rec.order : k_q;

  bpa_buddy_unit u_unit (
    .page_i  (p_q),
    .order_i (unit_ord),
    .upper_o (unit_upper),
    .buddy_o (unit_buddy)
  );

  // Smallest order whose block holds the requested page count.
  always_comb begin
    req_ord = bpa_pkg::OrdW'(bpa_pkg::CntW);
    for (int i = bpa_pkg::CntW; i >= 0; i--) begin
      if ((bpa_pkg::CntW+1)'(1) << i >= {1'b0, in_item_i.page_count}) begin
        req_ord = bpa_pkg::OrdW'(i);
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign init_link   = {1'b0, init_q};

  always_comb begin
    wr      = '0;
    wr.addr = p_q;
    unique case (state_q)
      S_INIT: begin
        wr.en_next  = 1'b1;
        wr.en_prev  = 1'b1;
        wr.en_free  = 1'b1;
        wr.en_order = 1'b1;
        wr.addr     = init_q;
        wr.data.nxt = bpa_pkg::LinkNil;
        wr.data.prv = bpa_pkg::LinkNil;
        if (init_q[bpa_pkg::MaxOrder-1:0] == '0) begin
          wr.data.free  = 1'b1;
          wr.data.order = MaxOrd;
          if (init_q != '0) begin
            wr.data.prv = init_link - BlkSz;
          end
          if (init_link + BlkSz < PoolSz) begin
            wr.data.nxt = init_link + BlkSz;
          end
        end
      end
      S_POP1, S_FIN1: begin
        wr.en_prev  = (rec.nxt != bpa_pkg::LinkNil);
        wr.addr     = rec.nxt[bpa_pkg::PageW-1:0];
        wr.data.prv = bpa_pkg::LinkNil;
      end
      S_UL1: begin
        wr.en_next  = (rec.prv != bpa_pkg::LinkNil);
        wr.addr     = rec.prv[bpa_pkg::PageW-1:0];
        wr.data.nxt = rec.nxt;
      end
      S_UL2: begin
        wr.en_prev  = (rt_q != bpa_pkg::LinkNil);
        wr.addr     = rt_q[bpa_pkg::PageW-1:0];
        wr.data.prv = lf_q;
      end
      S_UL3: begin
        wr.en_next  = 1'b1;
        wr.addr     = u_q;
        wr.data.nxt = bpa_pkg::LinkNil;
      end
      S_UL4: begin
        wr.en_prev  = 1'b1;
        wr.en_free  = 1'b1;
        wr.addr     = u_q;
        wr.data.prv = bpa_pkg::LinkNil;
      end
      S_SP2: begin
        wr.en_prev    = 1'b1;
        wr.en_free    = 1'b1;
        wr.en_order   = 1'b1;
        wr.data.prv   = bpa_pkg::LinkNil;
        wr.data.free  = 1'b1;
        wr.data.order = k_q;
      end
      S_SP3: begin
        wr.en_next    = 1'b1;
        wr.en_prev    = 1'b1;
        wr.en_free    = 1'b1;
        wr.en_order   = 1'b1;
        wr.addr       = hi_q;
        wr.data.nxt   = nx_q;
        wr.data.prv   = {1'b0, p_q};
        wr.data.free  = 1'b1;
        wr.data.order = k_q;
      end
      S_SP4: begin
        wr.en_prev  = (nx_q != bpa_pkg::LinkNil);
        wr.addr     = nx_q[bpa_pkg::PageW-1:0];
        wr.data.prv = {1'b0, hi_q};
      end
      S_SP5: begin
        wr.en_next  = 1'b1;
        wr.data.nxt = {1'b0, hi_q};
      end
      S_SP6: begin
        wr.en_next  = 1'b1;
        wr.data.nxt = nx_q;
      end
      S_SP7: begin
        wr.en_prev  = (nx_q != bpa_pkg::LinkNil);
        wr.addr     = nx_q[bpa_pkg::PageW-1:0];
        wr.data.prv = {1'b0, p_q};
      end
      S_FIN2: begin
        wr.en_next  = 1'b1;
        wr.en_prev  = 1'b1;
        wr.en_free  = 1'b1;
        wr.data.nxt = bpa_pkg::LinkNil;
        wr.data.prv = bpa_pkg::LinkNil;
      end
      S_PS0: begin
        wr.en_next    = 1'b1;
        wr.en_prev    = 1'b1;
        wr.en_free    = 1'b1;
        wr.en_order   = 1'b1;
        wr.addr       = u_q;
        wr.data.nxt   = head_q[pord_q];
        wr.data.prv   = bpa_pkg::LinkNil;
        wr.data.free  = 1'b1;
        wr.data.order = pord_q;
      end
      S_PS1: begin
        wr.en_prev  = (nx_q != bpa_pkg::LinkNil);
        wr.addr     = nx_q[bpa_pkg::PageW-1:0];
        wr.data.prv = {1'b0, u_q};
      end
      default: begin
        wr.addr = p_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      rd_ret_q    <= S_IDLE;
      sub_ret_q   <= S_IDLE;
      init_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= bpa_pkg::MaxOrder; i++) begin
        head_q[i] <= (i == bpa_pkg::MaxOrder) ? '0 : bpa_pkg::LinkNil;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == bpa_pkg::PageW'(bpa_pkg::NumPages - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q <= in_item_i.page_index;
            if (in_item_i.op == bpa_pkg::OpAlloc) begin
              ord_q <= req_ord;
              av_q  <= req_ord;
              if (req_ord > MaxOrd) begin
                res_q   <= '{status: bpa_pkg::StatusTooBig, block_start: '0};
                state_q <= S_DONE;
              end else begin
                res_q   <= '0;
                state_q <= S_SRCH;
              end
            end else if ({1'b0, in_item_i.page_index} < PoolSz) begin
              res_q    <= '0;
              addr_q   <= in_item_i.page_index;
              rd_ret_q <= S_FCHK;
              state_q  <= S_RDW;
            end else begin
              res_q   <= '0;
              state_q <= S_DONE;
            end
          end
        end
        S_RDW: begin
          state_q <= rd_ret_q;
        end
        S_SRCH: begin
          if (av_q > MaxOrd) begin
            res_q.status <= bpa_pkg::StatusNoBlock;
            state_q      <= S_DONE;
          end else if (head_q[av_q] == bpa_pkg::LinkNil) begin
            av_q <= av_q + 1'b1;
          end else begin
            o_q     <= av_q;
            state_q <= S_SPL;
          end
        end
        S_SPL: begin
          if (o_q > ord_q) begin
            p_q      <= head_q[o_q][bpa_pkg::PageW-1:0];
            addr_q   <= head_q[o_q][bpa_pkg::PageW-1:0];
            rd_ret_q <= S_POP1;
            state_q  <= S_RDW;
          end else if (head_q[ord_q] == bpa_pkg::LinkNil) begin
            res_q.status <= bpa_pkg::StatusNoBlock;
            state_q      <= S_DONE;
          end else begin
            p_q      <= head_q[ord_q][bpa_pkg::PageW-1:0];
            addr_q   <= head_q[ord_q][bpa_pkg::PageW-1:0];
            rd_ret_q <= S_FIN1;
            state_q  <= S_RDW;
          end
        end
        S_POP1: begin
          head_q[o_q] <= rec.nxt;
          if (rec.order == '0 || rec.order > MaxOrd) begin
            o_q     <= o_q - 1'b1;
            state_q <= S_SPL;
          end else begin
            k_q       <= rec.order - 1'b1;
            u_q       <= p_q;
            sub_ret_q <= S_SP2;
            state_q   <= S_UL0;
          end
        end
        S_UL0: begin
          addr_q   <= u_q;
          rd_ret_q <= S_UL1;
          state_q  <= S_RDW;
        end
        S_UL1: begin
          lf_q    <= rec.prv;
          rt_q    <= rec.nxt;
          uord_q  <= rec.order;
          state_q <= S_UL2;
        end
        S_UL2: begin
          state_q <= S_UL3;
        end
        S_UL3: begin
          if (uord_q <= MaxOrd && head_q[uord_q] == {1'b0, u_q}) begin
            head_q[uord_q] <= (lf_q != bpa_pkg::LinkNil) ? lf_q : rt_q;
          end
          state_q <= S_UL4;
        end
        S_UL4: begin
          state_q <= sub_ret_q;
        end
        S_SP2: begin
          nx_q <= head_q[k_q];
          hi_q <= unit_upper[bpa_pkg::PageW-1:0];
          if (unit_upper < bpa_pkg::SumW'(bpa_pkg::NumPages)) begin
            state_q <= S_SP3;
          end else begin
            state_q <= S_SP6;
          end
        end
        S_SP3: state_q <= S_SP4;
        S_SP4: state_q <= S_SP5;
        S_SP5, S_SP7: begin
          head_q[k_q] <= {1'b0, p_q};
          o_q         <= o_q - 1'b1;
          state_q     <= S_SPL;
        end
        S_SP6: state_q <= S_SP7;
        S_FIN1: begin
          head_q[ord_q] <= rec.nxt;
          state_q       <= S_FIN2;
        end
        S_FIN2: begin
          res_q.block_start <= p_q;
          state_q           <= S_DONE;
        end
        S_FCHK: begin
          if (rec.free) begin
            state_q <= S_DONE;
          end else begin
            pord_q    <= (rec.order > MaxOrd) ? MaxOrd : rec.order;
            o_q       <= (rec.order > MaxOrd) ? MaxOrd : rec.order;
            u_q       <= idx_q;
            sub_ret_q <= S_MG0;
            state_q   <= S_PS0;
          end
        end
        S_PS0: begin
          nx_q    <= head_q[pord_q];
          state_q <= S_PS1;
        end
        S_PS1: begin
          head_q[pord_q] <= {1'b0, u_q};
          state_q        <= sub_ret_q;
        end
        S_MG0: begin
          if (o_q >= MaxOrd) begin
            state_q <= S_DONE;
          end else if (head_q[o_q] == bpa_pkg::LinkNil) begin
            o_q <= o_q + 1'b1;
          end else begin
            p_q      <= head_q[o_q][bpa_pkg::PageW-1:0];
            addr_q   <= head_q[o_q][bpa_pkg::PageW-1:0];
            rd_ret_q <= S_MG1;
            state_q  <= S_RDW;
          end
        end
        S_MG1: begin
          if (unit_buddy == bpa_pkg::LinkNil) begin
            o_q     <= o_q + 1'b1;
            state_q <= S_MG0;
          end else begin
            addr_q   <= unit_buddy[bpa_pkg::PageW-1:0];
            rd_ret_q <= S_MG2;
            state_q  <= S_RDW;
          end
        end
        S_MG2: begin
          if (!rec.free || rec.order != o_q) begin
            o_q     <= o_q + 1'b1;
            state_q <= S_MG0;
          end else begin
            lo_q      <= (addr_q < p_q) ? addr_q : p_q;
            hi_q      <= (addr_q < p_q) ? p_q : addr_q;
            u_q       <= (addr_q < p_q) ? addr_q : p_q;
            sub_ret_q <= S_MG3;
            state_q   <= S_UL0;
          end
        end
        S_MG3: begin
          u_q       <= hi_q;
          sub_ret_q <= S_MG4;
          state_q   <= S_UL0;
        end
        S_MG4: begin
          u_q       <= lo_q;
          pord_q    <= o_q + 1'b1;
          sub_ret_q <= S_MG5;
          state_q   <= S_PS0;
        end
        S_MG5: begin
          o_q     <= o_q + 1'b1;
          state_q <= S_MG0;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/bpa_buddy_unit.sv
module bpa_buddy_unit (
  input  logic [bpa_pkg::PageW-1:0] page_i,
  input  logic [bpa_pkg::OrdW-1:0]  order_i,
  output logic [bpa_pkg::SumW-1:0]  upper_o,
  output logic [bpa_pkg::LinkW-1:0] buddy_o
);

  logic [bpa_pkg::SumW:0]   off;
  logic [bpa_pkg::SumW:0]   mask;
  logic [bpa_pkg::SumW:0]   page_ext;
  logic [bpa_pkg::SumW:0]   sum;

  assign page_ext = {{(bpa_pkg::SumW + 1 - bpa_pkg::PageW){1'b0}}, page_i};
  assign off      = (bpa_pkg::SumW + 1)'(1) << order_i;
  assign mask     = (off << 1) - (bpa_pkg::SumW + 1)'(1);
  assign sum      = page_ext + off;
  assign upper_o  = sum[bpa_pkg::SumW-1:0];

  // The upper half of a pair looks down for its buddy, the lower half looks up.
  always_comb begin
    buddy_o = bpa_pkg::LinkNil;
    if ((page_ext & mask) != '0) begin
      if (page_ext >= off) begin
        buddy_o = {1'b0, bpa_pkg::PageW'(page_ext - off)};
      end
    end else if (sum < (bpa_pkg::SumW + 1)'(bpa_pkg::NumPages)) begin
      buddy_o = {1'b0, sum[bpa_pkg::PageW-1:0]};
    end
  end

endmodule

### rtl/core/bpa_page_store.sv
module bpa_page_store (
  input  logic                      clk_i,
  input  logic [bpa_pkg::PageW-1:0] rd_addr_i,
  output bpa_pkg::page_rec_t        rd_data_o,
  input  bpa_pkg::page_wr_t         wr_i
);

  logic [bpa_pkg::LinkW-1:0] mem_next  [bpa_pkg::NumPages];
  logic [bpa_pkg::LinkW-1:0] mem_prev  [bpa_pkg::NumPages];
  logic                      mem_free  [bpa_pkg::NumPages];
  logic [bpa_pkg::OrdW-1:0]  mem_order [bpa_pkg::NumPages];

  always_ff @(posedge clk_i) begin
    if (wr_i.en_next) begin
      mem_next[wr_i.addr] <= wr_i.data.nxt;
    end
    if (wr_i.en_prev) begin
      mem_prev[wr_i.addr] <= wr_i.data.prv;
    end
    if (wr_i.en_free) begin
      mem_free[wr_i.addr] <= wr_i.data.free;
    end
    if (wr_i.en_order) begin
      mem_order[wr_i.addr] <= wr_i.data.order;
    end
    rd_data_o.nxt   <= mem_next[rd_addr_i];
    rd_data_o.prv   <= mem_prev[rd_addr_i];
    rd_data_o.free  <= mem_free[rd_addr_i];
    rd_data_o.order <= mem_order[rd_addr_i];
  end

endmodule

### bench/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps

module tb_buddy_page_allocator;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    bpa_pkg::in_item_t  req;
    bpa_pkg::out_item_t want;
  } job_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  bpa_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  bpa_pkg::out_item_t out_item_o;

  buddy_page_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow of the allocator's pool.
  logic [bpa_pkg::LinkW-1:0] head_q [bpa_pkg::MaxOrder+1];
  logic [bpa_pkg::LinkW-1:0] next_q [bpa_pkg::NumPages];
  logic [bpa_pkg::LinkW-1:0] prev_q [bpa_pkg::NumPages];
  logic                      free_q [bpa_pkg::NumPages];
  logic [bpa_pkg::OrdW-1:0]  ord_q  [bpa_pkg::NumPages];

  job_t               pending_jobs[$];
  bpa_pkg::out_item_t expected_results[$];
  int                 live_blocks[$];
  job_t               cur_job;
  logic               in_fire;
  int                 send_idle;
  int                 recv_idle;
  logic               hold_req;
  logic               hold_done;
  int                 hold_cnt;
  int                 errors;
  int                 cycles;

  function automatic void pool_reset();
    for (int o = 0; o <= bpa_pkg::MaxOrder; o++) head_q[o] = bpa_pkg::LinkNil;
    for (int i = 0; i < bpa_pkg::NumPages; i++) begin
      next_q[i] = bpa_pkg::LinkNil;
      prev_q[i] = bpa_pkg::LinkNil;
      free_q[i] = 1'b0;
      ord_q[i]  = '0;
    end
    for (int i = 0; i < (bpa_pkg::NumPages >> bpa_pkg::MaxOrder); i++) begin
      int p;
      p = i << bpa_pkg::MaxOrder;
      free_q[p] = 1'b1;
      ord_q[p]  = bpa_pkg::OrdW'(bpa_pkg::MaxOrder);
      prev_q[p] = (i != 0) ? bpa_pkg::LinkW'(p - (1 << bpa_pkg::MaxOrder)) : bpa_pkg::LinkNil;
      next_q[p] = (i + 1 < (bpa_pkg::NumPages >> bpa_pkg::MaxOrder)) ?
                  bpa_pkg::LinkW'(p + (1 << bpa_pkg::MaxOrder)) : bpa_pkg::LinkNil;
    end
    head_q[bpa_pkg::MaxOrder] = '0;
  endfunction

  function automatic void push_block(int p, int o);
    logic [bpa_pkg::LinkW-1:0] nx;
    nx = head_q[o];
    next_q[p] = nx;
    prev_q[p] = bpa_pkg::LinkNil;
    free_q[p] = 1'b1;
    ord_q[p]  = bpa_pkg::OrdW'(o);
    if (nx != bpa_pkg::LinkNil) prev_q[nx[bpa_pkg::PageW-1:0]] = bpa_pkg::LinkW'(p);
    head_q[o] = bpa_pkg::LinkW'(p);
  endfunction

  function automatic void detach_block(int p);
    logic [bpa_pkg::LinkW-1:0] lf, rt, hd;
    int o;
    lf = prev_q[p];
    rt = next_q[p];
    hd = rt;
    o  = int'(ord_q[p]);
    if (lf != bpa_pkg::LinkNil) begin
      next_q[lf[bpa_pkg::PageW-1:0]] = rt;
      hd = lf;
    end
    if (rt != bpa_pkg::LinkNil) prev_q[rt[bpa_pkg::PageW-1:0]] = lf;
    if (o <= bpa_pkg::MaxOrder && head_q[o] == bpa_pkg::LinkW'(p)) head_q[o] = hd;
    next_q[p] = bpa_pkg::LinkNil;
    prev_q[p] = bpa_pkg::LinkNil;
    free_q[p] = 1'b0;
  endfunction

  function automatic int take_head(int o);
    int p;
    logic [bpa_pkg::LinkW-1:0] nx;
    p  = int'(head_q[o][bpa_pkg::PageW-1:0]);
    nx = next_q[p];
    head_q[o] = nx;
    if (nx != bpa_pkg::LinkNil) prev_q[nx[bpa_pkg::PageW-1:0]] = bpa_pkg::LinkNil;
    return p;
  endfunction

  function automatic void halve_block(int p);
    int o, hi;
    logic [bpa_pkg::LinkW-1:0] nx;
    o = int'(ord_q[p]);
    if (o == 0 || o > bpa_pkg::MaxOrder) return;
    o--;
    hi = p + (1 << o);
    detach_block(p);
    nx = head_q[o];
    free_q[p] = 1'b1;
    prev_q[p] = bpa_pkg::LinkNil;
    ord_q[p]  = bpa_pkg::OrdW'(o);
    if (hi < bpa_pkg::NumPages) begin
      free_q[hi] = 1'b1;
      next_q[hi] = nx;
      prev_q[hi] = bpa_pkg::LinkW'(p);
      ord_q[hi]  = bpa_pkg::OrdW'(o);
      if (nx != bpa_pkg::LinkNil) prev_q[nx[bpa_pkg::PageW-1:0]] = bpa_pkg::LinkW'(hi);
      next_q[p] = bpa_pkg::LinkW'(hi);
    end else begin
      next_q[p] = nx;
      if (nx != bpa_pkg::LinkNil) prev_q[nx[bpa_pkg::PageW-1:0]] = bpa_pkg::LinkW'(p);
    end
    head_q[o] = bpa_pkg::LinkW'(p);
  endfunction

  function automatic int buddy_page(int p);
    int off;
    off = 1 << ord_q[p];
    if ((p & ((off << 1) - 1)) != 0) return (p >= off) ? p - off : -1;
    return (p + off < bpa_pkg::NumPages) ? p + off : -1;
  endfunction

  function automatic void coalesce_from(int first);
    for (int o = first; o < bpa_pkg::MaxOrder; o++) begin
      int p, b;
      if (head_q[o] == bpa_pkg::LinkNil) continue;
      p = int'(head_q[o][bpa_pkg::PageW-1:0]);
      b = buddy_page(p);
      if (b < 0 || !free_q[b] || ord_q[b] != bpa_pkg::OrdW'(o)) continue;
      detach_block((b < p) ? b : p);
      detach_block((b < p) ? p : b);
      push_block((b < p) ? b : p, o + 1);
    end
  endfunction

  function automatic bpa_pkg::out_item_t allocator_step(bpa_pkg::in_item_t req);
    bpa_pkg::out_item_t r;
    int cnt, want_ord, avail, p, o;
    r = '0;
    if (req.op == bpa_pkg::OpAlloc) begin
      cnt = (req.page_count == 0) ? 1 : int'(req.page_count);
      want_ord = 0;
      while ((1 << want_ord) < cnt) want_ord++;
      if (want_ord > bpa_pkg::MaxOrder) begin
        r.status = bpa_pkg::StatusTooBig;
        return r;
      end
      avail = want_ord;
      while (avail <= bpa_pkg::MaxOrder && head_q[avail] == bpa_pkg::LinkNil) avail++;
      if (avail > bpa_pkg::MaxOrder) begin
        r.status = bpa_pkg::StatusNoBlock;
        return r;
      end
      for (o = avail; o > want_ord; o--) halve_block(take_head(o));
      if (head_q[want_ord] == bpa_pkg::LinkNil) begin
        r.status = bpa_pkg::StatusNoBlock;
        return r;
      end
      p = take_head(want_ord);
      next_q[p] = bpa_pkg::LinkNil;
      prev_q[p] = bpa_pkg::LinkNil;
      free_q[p] = 1'b0;
      r.block_start = bpa_pkg::PageW'(p);
      return r;
    end
    p = int'(req.page_index);
    if (p < bpa_pkg::NumPages && !free_q[p]) begin
      o = int'(ord_q[p]);
      if (o > bpa_pkg::MaxOrder) o = bpa_pkg::MaxOrder;
      push_block(p, o);
      coalesce_from(o);
    end
    return r;
  endfunction

  // Predicts the item and tracks the live blocks so later frees can target them.
  function automatic void queue_request(logic op, int cnt, int idx);
    job_t j;
    j.req.op         = op;
    j.req.page_count = bpa_pkg::CntW'(cnt);
    j.req.page_index = bpa_pkg::PageW'(idx);
    j.want = allocator_step(j.req);
    if (op == bpa_pkg::OpAlloc && j.want.status == bpa_pkg::StatusOk)
      live_blocks.push_back(int'(j.want.block_start));
    pending_jobs.push_back(j);
  endfunction

  function automatic void queue_free_live(int k);
    int p;
    p = live_blocks[k];
    live_blocks.delete(k);
    queue_request(bpa_pkg::OpFree, $urandom_range(2047), p);
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++) begin
      int roll, cnt;
      roll = $urandom_range(99);
      if (roll < 4) begin
        queue_request(bpa_pkg::OpFree, $urandom_range(2047), $urandom_range(4095));
      end else if (live_blocks.size() != 0 &&
                   (roll < 50 || live_blocks.size() > 40)) begin
        queue_free_live($urandom_range(live_blocks.size() - 1));
      end else begin
        roll = $urandom_range(99);
        if (roll < 60) cnt = $urandom_range(16);
        else if (roll < 85) cnt = $urandom_range(128);
        else if (roll < 96) cnt = $urandom_range(1024);
        else cnt = $urandom_range(2047);
        queue_request(bpa_pkg::OpAlloc, cnt, $urandom_range(4095));
      end
    end
  endfunction

  task automatic drain();
    while (pending_jobs.size() != 0 || expected_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) expected_results.push_back(cur_job.want);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting: status %0d start %0d", $time,
                   out_item_o.status, out_item_o.block_start);
          errors++;
        end else begin
          if (out_item_o.status != expected_results[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     expected_results[0].status, out_item_o.status);
            errors++;
          end
          if (out_item_o.block_start != expected_results[0].block_start) begin
            $display("%0t: block_start expected %0d actual %0d", $time,
                     expected_results[0].block_start, out_item_o.block_start);
            errors++;
          end
          void'(expected_results.pop_front());
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle) begin
        cur_job    <= pending_jobs[0];
        in_item_i  <= pending_jobs[0].req;
        in_valid_i <= 1'b1;
        void'(pending_jobs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The long hold lets the block fill up and stall its input.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      if (hold_cnt < HoldCycles) hold_cnt <= hold_cnt + 1;
      else hold_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cur_job     = '0;
    out_ready_i = 1'b0;
    in_fire     = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    hold_cnt    = 0;
    errors      = 0;
    cycles      = 0;
    send_idle   = 20;
    recv_idle   = 76;
    pool_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: size extremes, exhaustion, frees of odd pages.
    queue_request(bpa_pkg::OpAlloc, 0, 4095);
    queue_request(bpa_pkg::OpAlloc, 1, 0);
    queue_request(bpa_pkg::OpAlloc, 1024, 0);
    queue_request(bpa_pkg::OpAlloc, 1025, 0);
    queue_request(bpa_pkg::OpAlloc, 2047, 0);
    queue_request(bpa_pkg::OpAlloc, 1024, 0);
    queue_request(bpa_pkg::OpAlloc, 1024, 0);
    queue_request(bpa_pkg::OpAlloc, 3, 0);
    queue_request(bpa_pkg::OpAlloc, 1, 0);
    queue_free_live(0);
    queue_request(bpa_pkg::OpFree, 0, live_blocks[0]);
    queue_request(bpa_pkg::OpFree, 2047, 4095);
    queue_request(bpa_pkg::OpFree, 1, 2049);
    while (live_blocks.size() != 0) queue_free_live(live_blocks.size() - 1);
    queue_request(bpa_pkg::OpAlloc, 512, 0);
    queue_request(bpa_pkg::OpAlloc, 7, 0);
    queue_request(bpa_pkg::OpAlloc, 1000, 0);
    queue_random(170);
    drain();

    send_idle = 76;
    recv_idle = 20;
    queue_random(180);
    drain();

    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    queue_random(180);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
